/* hdl/fccc_pkg.sv */
// ----------------------------------------------------------------------------
// fccc_pkg
// Shared types and constants of the facelet color calibrate/classify block.
// ----------------------------------------------------------------------------
package fccc_pkg;

	localparam int NUM_FACES_DEF         = 6;
	localparam int FACELETS_PER_FACE_DEF = 8;
	localparam int NUM_COLORS_DEF        = 6;
	localparam int FRACTION_BITS_DEF     = 4;

	localparam int          MASK_BITS    = 6;
	localparam logic [7:0]  MARGIN_RESET = 8'd25;

	localparam logic CMD_CALIBRATE = 1'b0;
	localparam logic CMD_CLASSIFY  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic wipe;      // clear one table entry after reset
		logic load;      // capture input item
		logic rd;        // issue memory read for current color
		logic wr;        // write calibrated entry
		logic acc;       // accumulate distance for current color
		logic root_go;   // start root
		logic clr_min;   // clear min tracker
		logic build;     // build mask from distances
	} fccc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic wipe_last;
		logic root_done;
		logic loc_ok;
		logic col_ok;
		logic is_classify;
	} fccc_sts_t;

endpackage

/* hdl/fccc_root.sv */
// ----------------------------------------------------------------------------
// fccc_root
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fccc_root #(
	parameter int IN_W = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IN_W-1:0]     value,
	output logic                done,
	output logic [IN_W/2:0]     root
);
	localparam int RW = IN_W / 2 + 1;
	localparam int RW2 = 2 * RW;
	localparam int CW = $clog2(RW + 1);

	logic [RW2-1:0] rem_q;
	logic [RW-1:0]  res_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic [RW2-1:0] rem_next;
	logic [RW2+1:0] trial;
	logic [RW2-1:0] src_q;

	always_comb begin
		rem_next = {rem_q[RW2-3:0], src_q[RW2-1 -: 2]};
		trial    = {2'b00, rem_next} - {{(RW2-RW){1'b0}}, res_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q <= RW2'(value);
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			src_q <= {src_q[RW2-3:0], 2'b00};
			if (!trial[RW2+1]) begin
				rem_q <= trial[RW2-1:0];
				res_q <= {res_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= rem_next;
				res_q <= {res_q[RW-2:0], 1'b0};
			end
		end
	end

	assign root = res_q;
endmodule

/* hdl/fccc_datapath.sv */
// ----------------------------------------------------------------------------
// fccc_datapath
// Reference table, distance accumulation, root, min tracking and mask build.
// ----------------------------------------------------------------------------
module fccc_datapath #(
	parameter int NUM_FACES         = fccc_pkg::NUM_FACES_DEF,
	parameter int FACELETS_PER_FACE = fccc_pkg::FACELETS_PER_FACE_DEF,
	parameter int NUM_COLORS        = fccc_pkg::NUM_COLORS_DEF,
	parameter int FRACTION_BITS     = fccc_pkg::FRACTION_BITS_DEF,
	localparam int CIW = $clog2(NUM_COLORS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fccc_pkg::fccc_cmd_t  cmd,
	input  logic [CIW-1:0]       col_idx,
	output fccc_pkg::fccc_sts_t  sts,
	input  logic                 command,
	input  logic [2:0]           face,
	input  logic [2:0]           facelet,
	input  logic [2:0]           color,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	input  logic [7:0]           margin,
	output logic [5:0]           mask
);
	localparam int CHW = 8 + FRACTION_BITS;
	localparam int DEPTH = NUM_FACES * FACELETS_PER_FACE * NUM_COLORS;
	localparam int AW = $clog2(DEPTH);
	localparam int SQW = 2 * CHW + 2;
	localparam int DW = SQW / 2 + 1;
	localparam int LW = DW + 1;

	logic [3*CHW:0]   mem [DEPTH];
	logic [3*CHW:0]   rd_q;
	logic [AW-1:0]    wipe_q;
	logic [AW-1:0]    base_q;
	logic [AW-1:0]    addr;
	logic             cmd_q;
	logic [2:0]       color_q;
	logic             loc_ok_q;
	logic [CHW-1:0]   s_r_q, s_g_q, s_b_q;
	logic             ref_v;
	logic [CHW-1:0]   ref_r, ref_g, ref_b;
	logic [CHW-1:0]   d_r, d_g, d_b;
	logic [SQW-1:0]   sum_q;
	logic             root_val_q;
	logic             root_done;
	logic [DW-1:0]    root;
	logic [DW-1:0]    dist_q [NUM_COLORS];
	logic [NUM_COLORS-1:0] dval_q;
	logic [DW-1:0]    min_q;
	logic             any_q;
	logic [CIW-1:0]   root_col_q;
	logic [LW-1:0]    limit;
	logic [2:0]       e_col;
	logic [AW-1:0]    e_base;

	always_comb begin
		e_base = AW'((32'(face) * FACELETS_PER_FACE + 32'(facelet)) * NUM_COLORS);
		e_col  = cmd.rd ? 3'(col_idx) : color_q;
		addr   = base_q + AW'(e_col);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			color_q  <= color;
			loc_ok_q <= (32'(face) < NUM_FACES) && (32'(facelet) < FACELETS_PER_FACE);
			base_q   <= e_base;
			s_r_q    <= CHW'(red) << FRACTION_BITS;
			s_g_q    <= CHW'(green) << FRACTION_BITS;
			s_b_q    <= CHW'(blue) << FRACTION_BITS;
		end
		rd_q <= mem[addr];
		if (cmd.wipe)
			mem[wipe_q] <= '0;
		else if (cmd.wr)
			mem[addr] <= ref_v ?
				{1'b1,
				 CHW'(({1'b0, s_r_q} + {1'b0, ref_r}) >> 1),
				 CHW'(({1'b0, s_g_q} + {1'b0, ref_g}) >> 1),
				 CHW'(({1'b0, s_b_q} + {1'b0, ref_b}) >> 1)} :
				{1'b1, s_r_q, s_g_q, s_b_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wipe_q <= '0;
		else if (cmd.wipe)
			wipe_q <= wipe_q + 1'b1;
	end

	assign {ref_v, ref_r, ref_g, ref_b} = rd_q;
	assign d_r = (s_r_q >= ref_r) ? s_r_q - ref_r : ref_r - s_r_q;
	assign d_g = (s_g_q >= ref_g) ? s_g_q - ref_g : ref_g - s_g_q;
	assign d_b = (s_b_q >= ref_b) ? s_b_q - ref_b : ref_b - s_b_q;

	// one channel multiply per term, summed in one accumulate step
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			sum_q <= SQW'(d_r) * SQW'(d_r) + SQW'(d_g) * SQW'(d_g) +
				SQW'(d_b) * SQW'(d_b);
			root_col_q <= col_idx;
			root_val_q <= ref_v;
		end
	end

	fccc_root #(.IN_W(SQW)) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_go),
		.value  (sum_q),
		.done   (root_done),
		.root   (root)
	);

	always_ff @(posedge clk) begin
		if (cmd.clr_min) begin
			any_q  <= 1'b0;
			dval_q <= '0;
		end else if (root_done && root_val_q) begin
			dist_q[root_col_q] <= root;
			dval_q[root_col_q] <= 1'b1;
			if (!any_q || root < min_q)
				min_q <= root;
			any_q <= 1'b1;
		end
	end

	assign limit = LW'(min_q) + LW'({margin, {FRACTION_BITS{1'b0}}});

	always_ff @(posedge clk) begin
		if (cmd.build) begin
			for (int k = 0; k < fccc_pkg::MASK_BITS; k++)
				mask[k] <= (k < NUM_COLORS) && loc_ok_q && any_q &&
					dval_q[k % NUM_COLORS] && (LW'(dist_q[k % NUM_COLORS]) < limit);
		end
	end

	assign sts.wipe_last   = wipe_q == AW'(DEPTH - 1);
	assign sts.root_done   = root_done;
	assign sts.loc_ok      = loc_ok_q;
	assign sts.col_ok      = 32'(color_q) < NUM_COLORS;
	assign sts.is_classify = cmd_q == fccc_pkg::CMD_CLASSIFY;
endmodule

/* hdl/fccc_ctrl.sv */
// ----------------------------------------------------------------------------
// fccc_ctrl
// Sequencer: calibrate read-modify-write, classify per-color distance loop.
// ----------------------------------------------------------------------------
module fccc_ctrl #(
	parameter int NUM_COLORS = fccc_pkg::NUM_COLORS_DEF,
	localparam int CIW = $clog2(NUM_COLORS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fccc_pkg::fccc_cmd_t  cmd,
	output logic [CIW-1:0]       col_idx,
	input  fccc_pkg::fccc_sts_t  sts
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DEC   = 4'd1;
	localparam logic [3:0] ST_RMW   = 4'd2;
	localparam logic [3:0] ST_READ  = 4'd3;
	localparam logic [3:0] ST_ACC   = 4'd4;
	localparam logic [3:0] ST_ROOT  = 4'd5;
	localparam logic [3:0] ST_BUILD = 4'd6;
	localparam logic [3:0] ST_WR    = 4'd7;
	localparam logic [3:0] ST_WIPE  = 4'd8;

	logic [3:0]     state_q;
	logic [CIW-1:0] col_q;
	logic           out_valid_q;
	logic           root_wait_q;
	logic           out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign col_idx   = col_q;

	always_comb begin
		cmd         = '0;
		cmd.wipe    = (state_q == ST_WIPE);
		cmd.load    = in_valid && in_ready;
		cmd.rd      = (state_q == ST_READ);
		cmd.wr      = (state_q == ST_WR);
		cmd.acc     = (state_q == ST_ACC);
		cmd.root_go = (state_q == ST_ROOT) && !root_wait_q;
		cmd.clr_min = (state_q == ST_DEC);
		cmd.build   = (state_q == ST_BUILD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			col_q       <= '0;
			out_valid_q <= 1'b0;
			root_wait_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_WIPE: begin
					if (sts.wipe_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && in_ready)
						state_q <= ST_DEC;
				end
				ST_DEC: begin
					col_q <= '0;
					if (!sts.is_classify)
						state_q <= (sts.loc_ok && sts.col_ok) ? ST_RMW : ST_IDLE;
					else
						state_q <= sts.loc_ok ? ST_READ : ST_BUILD;
				end
				ST_RMW:  state_q <= ST_WR;
				ST_WR:   state_q <= ST_IDLE;
				ST_READ: state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_ROOT;
				ST_ROOT: begin
					root_wait_q <= 1'b1;
					if (sts.root_done) begin
						root_wait_q <= 1'b0;
						if (32'(col_q) == NUM_COLORS - 1) begin
							state_q <= ST_BUILD;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_BUILD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* hdl/facelet_color_calibrate_classify.sv */
// ----------------------------------------------------------------------------
// facelet_color_calibrate_classify
// Per-facelet color reference table with nearest-color classification.
//
// Input channel (in_valid/in_ready): command, face, facelet, color, red,
// green, blue. Calibrate items write the table and give no result. Classify
// items give one candidate_mask on the output channel (out_valid/out_ready).
// Configuration channel (cfg_valid/cfg_ready) writes match_margin.
// A calibrate item steps through accept, decode, table read and write; one
// with a bad location or color returns to idle after decode. A classify item
// reads, squares and roots each color in turn, one root bit per cycle, in a
// single shared root unit, then builds the mask; a classify with a bad
// location skips the color loop and answers with an empty mask.
// One item is in flight at a time. A result not yet taken holds the next
// classify in its final step; input keeps flowing until then.
// After reset, in_ready stays low while the table is wiped; match_margin resets to 25.
// ----------------------------------------------------------------------------
module facelet_color_calibrate_classify #(
	parameter int NUM_FACES         = fccc_pkg::NUM_FACES_DEF,
	parameter int FACELETS_PER_FACE = fccc_pkg::FACELETS_PER_FACE_DEF,
	parameter int NUM_COLORS        = fccc_pkg::NUM_COLORS_DEF,
	parameter int FRACTION_BITS     = fccc_pkg::FRACTION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] match_margin,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [2:0] face,
	input  logic [2:0] facelet,
	input  logic [2:0] color,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] candidate_mask
);
	localparam int CIW = $clog2(NUM_COLORS);

	fccc_pkg::fccc_cmd_t cmd;
	fccc_pkg::fccc_sts_t sts;
	logic [CIW-1:0]      col_idx;
	logic [7:0]          margin_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			margin_q <= fccc_pkg::MARGIN_RESET;
		else if (cfg_valid)
			margin_q <= match_margin;
	end

	fccc_ctrl #(.NUM_COLORS(NUM_COLORS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.col_idx   (col_idx),
		.sts       (sts)
	);

	fccc_datapath #(
		.NUM_FACES         (NUM_FACES),
		.FACELETS_PER_FACE (FACELETS_PER_FACE),
		.NUM_COLORS        (NUM_COLORS),
		.FRACTION_BITS     (FRACTION_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.col_idx (col_idx),
		.sts     (sts),
		.command (command),
		.face    (face),
		.facelet (facelet),
		.color   (color),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.margin  (margin_q),
		.mask    (candidate_mask)
	);
endmodule

/* tb/facelet_color_calibrate_classify_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// facelet_color_calibrate_classify_tb
// Drives calibrate and classify items through the block, keeps its own copy of
// the reference table and margin, and checks every candidate mask in order.
// ----------------------------------------------------------------------------
module facelet_color_calibrate_classify_tb;

	localparam int NF = fccc_pkg::NUM_FACES_DEF;
	localparam int NL = fccc_pkg::FACELETS_PER_FACE_DEF;
	localparam int NC = fccc_pkg::NUM_COLORS_DEF;
	localparam int FB = fccc_pkg::FRACTION_BITS_DEF;
	localparam int SETTLE = 200;

	typedef struct {
		logic       cmd;
		logic [2:0] fc;
		logic [2:0] fl;
		logic [2:0] col;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		int         want;   // -1: use predictor
	} stim_t;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_valid = 0;
	logic [7:0] match_margin = 0;
	logic       in_valid = 0;
	logic       command = 0;
	logic [2:0] face = 0, facelet = 0, color = 0;
	logic [7:0] red = 0, green = 0, blue = 0;
	logic       out_ready = 0;
	logic       cfg_ready, in_ready, out_valid;
	logic [5:0] candidate_mask;

	facelet_color_calibrate_classify uut (.*);

	always #10 clk = ~clk;

	logic [11:0] ref_chan [NF*NL*NC][3];
	bit          ref_set [NF*NL*NC];
	logic [7:0]  cur_margin;
	logic [5:0]  mask_queue [$];
	int          errors = 0, n_items = 0, n_masks = 0;
	int          send_idle = 0, recv_idle = 0;

	task automatic report(string what, int got, int exp);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	function automatic logic [31:0] isqrt(logic [31:0] v);
		logic [31:0] res, bitv;
		res = 0;
		bitv = 32'h4000_0000;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// advance the model table; return the mask for classify, -1 for none
	function automatic int apply_item(stim_t s);
		logic [11:0] smp [3];
		logic [31:0] col_dist [NC];
		logic [31:0] sum, d, mn, lim;
		int base, e;
		bit any;
		logic [5:0] m;
		smp[0] = {s.r, 4'b0};
		smp[1] = {s.g, 4'b0};
		smp[2] = {s.b, 4'b0};
		if (s.fc >= NF || s.fl >= NL)
			return (s.cmd == fccc_pkg::CMD_CALIBRATE) ? -1 : 0;
		base = (s.fc * NL + s.fl) * NC;
		if (s.cmd == fccc_pkg::CMD_CALIBRATE) begin
			if (s.col < NC) begin
				e = base + s.col;
				for (int c = 0; c < 3; c++)
					ref_chan[e][c] = ref_set[e] ?
						12'(({1'b0, smp[c]} + {1'b0, ref_chan[e][c]}) >> 1) : smp[c];
				ref_set[e] = 1;
			end
			return -1;
		end
		any = 0;
		mn = 0;
		m = 0;
		for (int k = 0; k < NC; k++) begin
			if (ref_set[base+k]) begin
				sum = 0;
				for (int c = 0; c < 3; c++) begin
					d = (smp[c] >= ref_chan[base+k][c]) ? smp[c] - ref_chan[base+k][c]
						: ref_chan[base+k][c] - smp[c];
					sum += d * d;
				end
				col_dist[k] = isqrt(sum);
				if (!any || col_dist[k] < mn) mn = col_dist[k];
				any = 1;
			end
		end
		if (any) begin
			lim = mn + (32'(cur_margin) << FB);
			for (int k = 0; k < NC && k < fccc_pkg::MASK_BITS; k++)
				if (ref_set[base+k] && col_dist[k] < lim) m[k] = 1;
		end
		return m;
	endfunction

	task automatic send_item(stim_t s);
		int exp;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		command <= s.cmd; face <= s.fc; facelet <= s.fl; color <= s.col;
		red <= s.r; green <= s.g; blue <= s.b;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		exp = apply_item(s);
		if (s.want >= 0 && exp != s.want) report("table row", exp, s.want);
		if (exp >= 0) mask_queue = {mask_queue, 6'(exp)};
		n_items++;
		@(negedge clk);
	endtask

	task automatic write_margin(logic [7:0] v);
		in_valid <= 0;
		wait (mask_queue.size() == 0);
		repeat (SETTLE) @(negedge clk);
		match_margin <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cur_margin = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic stim_t rnd_item(int loc_cells);
		stim_t s;
		s.cmd = $urandom_range(99) < 55;
		if ($urandom_range(99) < 8) begin
			s.fc = 3'($urandom); s.fl = 3'($urandom); s.col = 3'($urandom);
		end else begin
			s.fc = 3'($urandom_range(NF-1));
			s.fl = 3'($urandom_range(loc_cells-1));
			s.col = ($urandom_range(99) < 5) ? 3'($urandom_range(7, NC)) :
				3'($urandom_range(NC-1));
		end
		s.r = 8'($urandom); s.g = 8'($urandom); s.b = 8'($urandom);
		s.want = -1;
		return s;
	endfunction

	always @(negedge clk)
		out_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) begin
			if (mask_queue.size() == 0) begin
				report("unexpected mask", candidate_mask, -1);
			end else begin
				if (candidate_mask != mask_queue[0])
					report("candidate_mask", candidate_mask, mask_queue[0]);
				void'(mask_queue.pop_front());
				n_masks++;
			end
		end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	stim_t table_rows [] = '{
		'{fccc_pkg::CMD_CLASSIFY,  3'd0, 3'd0, 3'd0, 8'd0,   8'd0,   8'd0,   0},
		'{fccc_pkg::CMD_CLASSIFY,  3'd6, 3'd0, 3'd0, 8'd10,  8'd10,  8'd10,  0},
		'{fccc_pkg::CMD_CLASSIFY,  3'd0, 3'd7, 3'd0, 8'd10,  8'd10,  8'd10,  0},
		'{fccc_pkg::CMD_CALIBRATE, 3'd0, 3'd0, 3'd0, 8'd0,   8'd0,   8'd0,   -1},
		'{fccc_pkg::CMD_CALIBRATE, 3'd0, 3'd0, 3'd1, 8'd255, 8'd255, 8'd255, -1},
		'{fccc_pkg::CMD_CLASSIFY,  3'd0, 3'd0, 3'd5, 8'd0,   8'd0,   8'd0,   1},
		'{fccc_pkg::CMD_CLASSIFY,  3'd0, 3'd0, 3'd0, 8'd255, 8'd255, 8'd255, 2},
		'{fccc_pkg::CMD_CALIBRATE, 3'd7, 3'd0, 3'd0, 8'd1,   8'd2,   8'd3,   -1},
		'{fccc_pkg::CMD_CALIBRATE, 3'd0, 3'd0, 3'd6, 8'd1,   8'd2,   8'd3,   -1},
		'{fccc_pkg::CMD_CALIBRATE, 3'd0, 3'd0, 3'd7, 8'd1,   8'd2,   8'd3,   -1},
		'{fccc_pkg::CMD_CALIBRATE, 3'd0, 3'd0, 3'd0, 8'd255, 8'd0,   8'd255, -1},
		'{fccc_pkg::CMD_CALIBRATE, 3'd0, 3'd0, 3'd2, 8'd130, 8'd128, 8'd128, -1},
		'{fccc_pkg::CMD_CALIBRATE, 3'd0, 3'd0, 3'd3, 8'd128, 8'd140, 8'd128, -1},
		'{fccc_pkg::CMD_CALIBRATE, 3'd0, 3'd0, 3'd4, 8'd170, 8'd85,  8'd1,   -1},
		'{fccc_pkg::CMD_CALIBRATE, 3'd0, 3'd0, 3'd5, 8'd85,  8'd170, 8'd254, -1},
		'{fccc_pkg::CMD_CLASSIFY,  3'd0, 3'd0, 3'd0, 8'd128, 8'd128, 8'd128, -1},
		'{fccc_pkg::CMD_CLASSIFY,  3'd0, 3'd0, 3'd0, 8'd131, 8'd129, 8'd128, -1},
		'{fccc_pkg::CMD_CALIBRATE, 3'd5, 3'd7, 3'd5, 8'd255, 8'd255, 8'd0,   -1},
		'{fccc_pkg::CMD_CLASSIFY,  3'd5, 3'd7, 3'd0, 8'd0,   8'd0,   8'd255, 32},
		'{fccc_pkg::CMD_CLASSIFY,  3'd7, 3'd7, 3'd7, 8'd255, 8'd255, 8'd255, 0}
	};

	initial begin
		cur_margin = fccc_pkg::MARGIN_RESET;
		foreach (ref_set[i]) ref_set[i] = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		foreach (table_rows[i]) send_item(table_rows[i]);

		write_margin(8'd0);
		send_item('{fccc_pkg::CMD_CLASSIFY, 3'd0, 3'd0, 3'd0, 8'd128, 8'd128, 8'd128, 0});
		write_margin(8'd255);
		send_item('{fccc_pkg::CMD_CLASSIFY, 3'd0, 3'd0, 3'd0, 8'd128, 8'd128, 8'd128, 63});

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 26 : (ph == 1) ? 63 : 0;
			recv_idle = (ph == 0) ? 63 : (ph == 1) ? 26 : 0;
			write_margin(ph == 0 ? 8'd2 : ph == 1 ? 8'd25 : 8'($urandom_range(1, 60)));
			// mostly a few locations so tables fill and averaging repeats
			for (int i = 0; i < 250; i++)
				send_item(rnd_item(i < 200 ? 2 : NL));
		end

		in_valid <= 0;
		wait (mask_queue.size() == 0);
		repeat (SETTLE) @(negedge clk);
		$display("covered %0d items, %0d masks, margins 0/2/25/255 and random, three idle mixes",
			n_items, n_masks);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
